// ===== hw/rtl/ecrm_pkg.sv =====
package ecrm_pkg;

  // Field widths
  localparam int unsigned LenW    = 31;
  localparam int unsigned RunW    = 32;
  localparam int unsigned KindW   = 3;

  // Depth of the command queue between front and back
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Operation kinds as they appear on op_kind
  typedef enum logic [KindW-1:0] {
    KindMatch = 3'd0,
    KindIns   = 3'd1,
    KindDel   = 3'd2,
    KindSoft  = 3'd3,
    KindNone  = 3'd4
  } ecrm_kind_e;

  // One classified edit: optional match, optional second op, optional flush
  typedef struct packed {
    logic              m_valid;
    logic [LenW-1:0]   m_len;
    logic              o_valid;
    ecrm_kind_e        o_kind;
    logic [LenW-1:0]   o_len;
    logic              flush;
  } ecrm_cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ecrm_qstat_t;

endpackage

// ===== hw/rtl/edit_to_cigar_run_merger.sv =====
// Edit to CIGAR run merger.
// Input channel (in_valid_i / in_stall_o): one alignment edit per word, with
// its reference and read lengths, the empty-sequence flag, has_edit and
// end_of_mapping. A word is taken at a clock edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i): one merged operation per word
// with run_length_o, op_kind_o and last_of_mapping_o, held while stalled.
// The front stage classifies each edit into up to three elementary steps
// (match, insertion/deletion/soft clip, flush) and queues it in a two-entry
// command queue; the back stage runs one step per cycle against the open run
// while the queue holds a command and the output slot is free. Each edit takes
// one step per present step. Words that neither edit nor end are dropped.
// A run closed by a word reaches the output through the front's command register,
// the queue and the output register; a run stays open until its kind changes or
// the mapping ends.
// Reset (rst_ni low, asynchronous) empties the queue and the output register
// and closes the open run. While the receiver stalls a valid output word, that word holds,
// the back stage pauses, and the queue and front keep filling until they
// raise in_stall_o.
module edit_to_cigar_run_merger
  import ecrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LenW-1:0]   ref_len_i,
  input  logic [LenW-1:0]   read_len_i,
  input  logic              sequence_empty_i,
  input  logic              has_edit_i,
  input  logic              end_of_mapping_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RunW-1:0]   run_length_o,
  output logic [KindW-1:0]  op_kind_o,
  output logic              last_of_mapping_o
);

  ecrm_qstat_t qstat;
  ecrm_cmd_t   push_cmd;
  ecrm_cmd_t   head_cmd;
  logic        push;
  logic        pop;

  ecrm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .ref_len_i        (ref_len_i),
    .read_len_i       (read_len_i),
    .sequence_empty_i (sequence_empty_i),
    .has_edit_i       (has_edit_i),
    .end_of_mapping_i (end_of_mapping_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  ecrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .qstat_o (qstat)
  );

  ecrm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head_cmd),
    .qstat_i           (qstat),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .run_length_o      (run_length_o),
    .op_kind_o         (op_kind_o),
    .last_of_mapping_o (last_of_mapping_o)
  );

endmodule

// ===== hw/rtl/ecrm_front.sv =====
module ecrm_front
  import ecrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LenW-1:0]   ref_len_i,
  input  logic [LenW-1:0]   read_len_i,
  input  logic              sequence_empty_i,
  input  logic              has_edit_i,
  input  logic              end_of_mapping_i,
  input  ecrm_qstat_t       qstat_i,
  output logic              push_o,
  output ecrm_cmd_t         cmd_o
);

  logic      cmd_valid_q, cmd_valid_d;
  ecrm_cmd_t cmd_q;
  ecrm_cmd_t cls;
  logic      accept;
  logic      useful;

  // Classify the incoming edit by its two lengths
  always_comb begin
    cls        = '0;
    cls.o_kind = KindNone;
    cls.flush  = end_of_mapping_i;
    if (has_edit_i) begin
      priority if (ref_len_i == read_len_i) begin
        cls.m_valid = 1'b1;
        cls.m_len   = ref_len_i;
      end else if ((ref_len_i == '0) && sequence_empty_i) begin
        cls.o_valid = 1'b1;
        cls.o_kind  = KindSoft;
        cls.o_len   = read_len_i;
      end else if (ref_len_i > read_len_i) begin
        cls.m_valid = (read_len_i != '0);
        cls.m_len   = read_len_i;
        cls.o_valid = 1'b1;
        cls.o_kind  = KindDel;
        cls.o_len   = ref_len_i - read_len_i;
      end else begin
        cls.m_valid = (ref_len_i != '0);
        cls.m_len   = ref_len_i;
        cls.o_valid = 1'b1;
        cls.o_kind  = KindIns;
        cls.o_len   = read_len_i - ref_len_i;
      end
    end
  end

  // Hold the input while the staged command cannot enter the queue
  assign in_stall_o = cmd_valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign useful     = has_edit_i || end_of_mapping_i;
  assign push_o     = cmd_valid_q && !qstat_i.full;
  assign cmd_o      = cmd_q;

  // Drop bare words that neither edit nor flush
  assign cmd_valid_d = (cmd_valid_q && !push_o) || (accept && useful);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && useful) begin
      cmd_q <= cls;
    end
  end

endmodule

// ===== hw/rtl/ecrm_queue.sv =====
module ecrm_queue
  import ecrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ecrm_cmd_t   cmd_i,
  input  logic        pop_i,
  output ecrm_cmd_t   head_o,
  output ecrm_qstat_t qstat_o
);

  ecrm_cmd_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/ecrm_back.sv =====
module ecrm_back
  import ecrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecrm_cmd_t         head_i,
  input  ecrm_qstat_t       qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RunW-1:0]   run_length_o,
  output logic [KindW-1:0]  op_kind_o,
  output logic              last_of_mapping_o
);

  ecrm_kind_e       open_kind_q, open_kind_d;
  logic [RunW-1:0]  open_len_q, open_len_d;
  logic             m_done_q, m_done_d;
  logic             o_done_q, o_done_d;
  logic             out_valid_q, out_valid_d;
  logic [RunW-1:0]  out_len_q, out_len_d;
  ecrm_kind_e       out_kind_q, out_kind_d;
  logic             out_last_q, out_last_d;

  logic             step;
  logic             need_m, need_o;
  logic             emit;
  logic             flush_step;
  ecrm_kind_e       op_kind;
  logic [LenW-1:0]  op_len;
  logic [RunW:0]    sum;

  // Advance one elementary step when the queue holds a command and the output word slot is free
  assign step   = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign need_m = head_i.m_valid && !m_done_q;
  assign need_o = head_i.o_valid && !o_done_q;
  assign flush_step = step && !need_m && !need_o;

  assign op_kind = need_m ? KindMatch : head_i.o_kind;
  assign op_len  = need_m ? head_i.m_len : head_i.o_len;
  assign sum     = {1'b0, open_len_q} + {{(RunW + 1 - LenW){1'b0}}, op_len};

  // Release the head once its last step runs
  assign pop_o = step && ((need_m && !head_i.o_valid && !head_i.flush) ||
                          (!need_m && need_o && !head_i.flush) ||
                          (!need_m && !need_o));

  // Merge the step into the open run, or close and emit it
  always_comb begin
    open_kind_d = open_kind_q;
    open_len_d  = open_len_q;
    emit        = 1'b0;
    out_len_d   = out_len_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (step) begin
      if (need_m || need_o) begin
        if (open_kind_q == KindNone) begin
          open_kind_d = op_kind;
          open_len_d  = RunW'(op_len);
        end else if (open_kind_q == op_kind) begin
          open_len_d  = sum[RunW] ? {RunW{1'b1}} : sum[RunW-1:0];
        end else begin
          emit        = 1'b1;
          out_len_d   = open_len_q;
          out_kind_d  = open_kind_q;
          out_last_d  = 1'b0;
          open_kind_d = op_kind;
          open_len_d  = RunW'(op_len);
        end
      end else begin
        emit        = 1'b1;
        out_len_d   = open_len_q;
        out_kind_d  = open_kind_q;
        out_last_d  = 1'b1;
        open_kind_d = KindNone;
        open_len_d  = '0;
      end
    end
  end

  // Track which steps of the head are done
  always_comb begin
    m_done_d = m_done_q;
    o_done_d = o_done_q;
    if (pop_o) begin
      m_done_d = 1'b0;
      o_done_d = 1'b0;
    end else if (step && need_m) begin
      m_done_d = 1'b1;
    end else if (step && need_o) begin
      o_done_d = 1'b1;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_kind_q <= KindNone;
      open_len_q  <= '0;
      m_done_q    <= 1'b0;
      o_done_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      open_kind_q <= open_kind_d;
      open_len_q  <= open_len_d;
      m_done_q    <= m_done_d;
      o_done_q    <= o_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_len_q  <= out_len_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign run_length_o      = out_len_q;
  assign op_kind_o         = out_kind_q;
  assign last_of_mapping_o = out_last_q;

  // A run of kind none carries no length
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_kind_q == KindNone |-> open_len_q == '0)
    else $error("open run of kind none has nonzero length");

  // Never release an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !qstat_i.empty)
    else $error("pop while queue empty");

  // A flush leaves no run open and shows a last word
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_step |=> (open_kind_q == KindNone) && out_valid_q && out_last_q)
    else $error("flush did not close the run");

  // Partial progress only on a present head
  a_done_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_done_q || o_done_q) |-> !qstat_i.empty)
    else $error("step progress without a head command");

endmodule

// ===== test/cigar_run_checker.sv =====
`timescale 1ns / 1ps

module cigar_run_checker
  import ecrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [LenW-1:0]   ref_len_i,
  input  logic [LenW-1:0]   read_len_i,
  input  logic              sequence_empty_i,
  input  logic              has_edit_i,
  input  logic              end_of_mapping_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [RunW-1:0]   run_length_i,
  input  logic [KindW-1:0]  op_kind_i,
  input  logic              last_of_mapping_i,
  output int unsigned       error_count_o,
  output int unsigned       ops_pending_o
);

  typedef struct packed {
    logic [RunW-1:0] len;
    ecrm_kind_e      kind;
    logic            last;
  } cigar_op_t;

  cigar_op_t       expected_ops[$];
  ecrm_kind_e      run_kind = KindNone;
  logic [RunW-1:0] run_len = '0;
  int unsigned     errors = 0;
  int unsigned     pending = 0;

  assign error_count_o = errors;
  assign ops_pending_o = pending;

  // Extend the open run, or close it and open a new one of another kind
  function automatic void extend_run(ecrm_kind_e kind, logic [RunW-1:0] len);
    logic [RunW:0] sum;
    if (run_kind == KindNone) begin
      run_kind = kind;
      run_len  = len;
    end else if (run_kind == kind) begin
      sum     = {1'b0, run_len} + {1'b0, len};
      run_len = sum[RunW] ? '1 : sum[RunW-1:0];
    end else begin
      expected_ops.insert(expected_ops.size(),
                          '{len: run_len, kind: run_kind, last: 1'b0});
      run_kind = kind;
      run_len  = len;
    end
  endfunction

  // Classify one edit into its operations, then flush on end of mapping
  function automatic void apply_word(logic [LenW-1:0] f, logic [LenW-1:0] t,
                                     logic se, logic he, logic em);
    logic [RunW-1:0] f_ext;
    logic [RunW-1:0] t_ext;
    f_ext = {1'b0, f};
    t_ext = {1'b0, t};
    if (he) begin
      if (f == t) begin
        extend_run(KindMatch, f_ext);
      end else if (f == '0 && se) begin
        extend_run(KindSoft, t_ext);
      end else if (f > t) begin
        if (t != '0) extend_run(KindMatch, t_ext);
        extend_run(KindDel, f_ext - t_ext);
      end else begin
        if (f != '0) extend_run(KindMatch, f_ext);
        extend_run(KindIns, t_ext - f_ext);
      end
    end
    if (em) begin
      // an empty mapping yields a zero-length none op
      expected_ops.insert(expected_ops.size(),
                          '{len: (run_kind == KindNone) ? '0 : run_len,
                            kind: run_kind, last: 1'b1});
      run_kind = KindNone;
      run_len  = '0;
    end
  endfunction

  // Track accepted words on both channels and compare each output word
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cigar_op_t want;
    if (!rst_ni) begin
      expected_ops.delete();
      run_kind = KindNone;
      run_len  = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        apply_word(ref_len_i, read_len_i, sequence_empty_i, has_edit_i,
                   end_of_mapping_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_ops.size() == 0) begin
          $display("%0t: unexpected op: expected none, got len %0d kind %0d last %0b",
                   $time, run_length_i, op_kind_i, last_of_mapping_i);
          errors++;
        end else begin
          want = expected_ops.pop_front();
          if (run_length_i !== want.len) begin
            $display("%0t: run_length expected %0d, got %0d",
                     $time, want.len, run_length_i);
            errors++;
          end
          if (op_kind_i !== want.kind) begin
            $display("%0t: op_kind expected %0d, got %0d",
                     $time, want.kind, op_kind_i);
            errors++;
          end
          if (last_of_mapping_i !== want.last) begin
            $display("%0t: last_of_mapping expected %0b, got %0b",
                     $time, want.last, last_of_mapping_i);
            errors++;
          end
        end
      end
    end
    pending = expected_ops.size();
  end

endmodule

// ===== test/tb_edit_to_cigar_run_merger.sv =====
`timescale 1ns / 1ps

module tb_edit_to_cigar_run_merger;
  import ecrm_pkg::*;

  localparam int unsigned     NumRandom   = 130;
  localparam int unsigned     IdleLimit   = 2000;
  localparam int unsigned     DrainCycles = 20;
  localparam logic [LenW-1:0] LenMax      = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [LenW-1:0]   ref_len = '0;
  logic [LenW-1:0]   read_len = '0;
  logic              sequence_empty = 1'b0;
  logic              has_edit = 1'b0;
  logic              end_of_mapping = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RunW-1:0]   run_length;
  logic [KindW-1:0]  op_kind;
  logic              last_of_mapping;
  logic              calm = 1'b0;
  int unsigned       error_count;
  int unsigned       ops_pending;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  edit_to_cigar_run_merger DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .ref_len_i         (ref_len),
    .read_len_i        (read_len),
    .sequence_empty_i  (sequence_empty),
    .has_edit_i        (has_edit),
    .end_of_mapping_i  (end_of_mapping),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .run_length_o      (run_length),
    .op_kind_o         (op_kind),
    .last_of_mapping_o (last_of_mapping)
  );

  cigar_run_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .ref_len_i         (ref_len),
    .read_len_i        (read_len),
    .sequence_empty_i  (sequence_empty),
    .has_edit_i        (has_edit),
    .end_of_mapping_i  (end_of_mapping),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .run_length_i      (run_length),
    .op_kind_i         (op_kind),
    .last_of_mapping_i (last_of_mapping),
    .error_count_o     (error_count),
    .ops_pending_o     (ops_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Lengths: mostly small so runs merge, some full-width, some near the top
  function automatic logic [LenW-1:0] rand_len();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return LenW'($urandom_range(0, 20));
      6, 7:             return r[LenW-1:0];
      8:                return LenMax - LenW'($urandom_range(0, 3));
      default:          return '0;
    endcase
  endfunction

  // Drive one word after an optional gap and hold it until taken
  task automatic send_word(input logic [LenW-1:0] f, input logic [LenW-1:0] t,
                           input logic se, input logic he, input logic em);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ref_len        <= f;
    read_len       <= t;
    sequence_empty <= se;
    has_edit       <= he;
    end_of_mapping <= em;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every expected op has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (ops_pending != 0);
    @(posedge clk);
  endtask

  // Receiver stalls at random, but never starts a stall during calm stretches
  initial begin : stall_gen
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = 1 + idle_len();
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned edits;
    logic        close_on_edit;
    logic        paused;
    logic [LenW-1:0] f;
    logic [LenW-1:0] t;
    logic        se;
    sent   = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty mapping, then a word that neither edits nor ends
    send_word('0, '0, 1'b0, 1'b0, 1'b1);
    send_word(LenMax, LenMax, 1'b1, 1'b0, 1'b0);
    // Zero-length match closed by soft clips, then match+deletion, match+insertion
    send_word('0, '0, 1'b0, 1'b1, 1'b0);
    send_word('0, 31'd5, 1'b1, 1'b1, 1'b0);
    send_word('0, 31'd5, 1'b1, 1'b1, 1'b0);
    send_word(31'd7, 31'd3, 1'b0, 1'b1, 1'b0);
    send_word(31'd3, 31'd7, 1'b1, 1'b1, 1'b1);
    // Saturate a match run
    send_word(LenMax, LenMax, 1'b0, 1'b1, 1'b0);
    send_word(LenMax, LenMax, 1'b0, 1'b1, 1'b0);
    send_word(LenMax, LenMax, 1'b1, 1'b1, 1'b0);
    send_word('0, '0, 1'b0, 1'b0, 1'b1);
    // Pure insertion, then a saturating deletion run
    send_word('0, LenMax, 1'b0, 1'b1, 1'b0);
    send_word(LenMax, '0, 1'b1, 1'b1, 1'b0);
    send_word(LenMax, '0, 1'b0, 1'b1, 1'b0);
    send_word(LenMax, '0, 1'b0, 1'b1, 1'b0);
    // Full-length soft clip, zero match with the flag set, edit with end
    send_word('0, LenMax, 1'b1, 1'b1, 1'b0);
    send_word('0, '0, 1'b1, 1'b1, 1'b0);
    send_word(31'd5, 31'd5, 1'b1, 1'b1, 1'b1);
    send_word(31'd1, '0, 1'b0, 1'b1, 1'b0);
    send_word('0, 31'd1, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // Random mappings with occasional noise and early flushes
    while (sent < NumRandom) begin
      calm          = ($urandom_range(0, 5) == 0);
      edits         = $urandom_range(1, 8);
      close_on_edit = 1'($urandom_range(0, 1));
      for (int i = 0; i < edits; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_word(rand_len(), rand_len(), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          end else begin
            send_word(rand_len(), rand_len(), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
            sent++;
          end
        end
        f  = rand_len();
        t  = rand_len();
        se = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0: t = f;
          1: begin
            f  = '0;
            se = 1'b1;
          end
          default: ;
        endcase
        send_word(f, t, se, 1'b1, close_on_edit && (i == edits - 1));
        sent++;
      end
      if (!close_on_edit) begin
        send_word(rand_len(), rand_len(), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        sent++;
      end
      if (!paused && sent >= NumRandom / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    calm = 1'b0;

    // Let the last ops out, then watch for strays
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
